[hdl/pcfd_pkg.sv]
// shared types and constants of the per-channel flood detector
package pcfd_pkg;

    localparam int CH_ID_W   = 5;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_LIMIT  = 1'b1;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 16'd2;
    localparam logic [CFG_W-1:0] LIMIT_RESET  = 16'd5;
    localparam logic [CFG_W-1:0] COUNT_MAX    = 16'hFFFF;
    localparam logic [CFG_W-1:0] COUNT_ONE    = 16'd1;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_DETACH   = 2'd1,
        EV_REATTACH = 2'd2
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [CFG_W-1:0]  count;
    } entry_t;

    typedef struct packed {
        logic               emit;
        logic               finish;
        event_t             ev;
        logic [CH_ID_W-1:0] ch;
    } out_cmd_t;

    typedef struct packed {
        logic can_emit;
        logic can_finish;
        logic pend_valid;
    } out_stat_t;

endpackage

[hdl/pcfd_msg_if.sv]
// message channel interface
interface pcfd_msg_if;
    import pcfd_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [CH_ID_W-1:0] channel_id;
    logic               channel_detached;
    logic [TIME_W-1:0]  now_seconds;

    modport source (
        output valid, mode, channel_id, channel_detached, now_seconds,
        input  ready
    );
    modport sink (
        input  valid, mode, channel_id, channel_detached, now_seconds,
        output ready
    );
endinterface

[hdl/pcfd_res_if.sv]
// result channel interface
interface pcfd_res_if;
    import pcfd_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         event_res;
    logic [CH_ID_W-1:0] target_channel;
    logic               last;

    modport source (
        output valid, event_res, target_channel, last,
        input  ready
    );
    modport sink (
        input  valid, event_res, target_channel, last,
        output ready
    );
endinterface

[hdl/pcfd_entry_mem.sv]
// channel entry memory, one write port, one registered read port
module pcfd_entry_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  pcfd_pkg::entry_t wdata,
    input  logic [AW-1:0]    raddr,
    output pcfd_pkg::entry_t rdata
);
    import pcfd_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

[hdl/pcfd_out_stage.sv]
// result staging: one pending result plus the output register, marks last
module pcfd_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  pcfd_pkg::out_cmd_t  cmd,
    output pcfd_pkg::out_stat_t stat,
    pcfd_res_if.source          res
);
    import pcfd_pkg::*;

    logic               out_valid_reg, out_valid_next;
    event_t             out_ev_reg, out_ev_next;
    logic [CH_ID_W-1:0] out_ch_reg, out_ch_next;
    logic               out_last_reg, out_last_next;
    logic               pend_valid_reg, pend_valid_next;
    event_t             pend_ev_reg, pend_ev_next;
    logic [CH_ID_W-1:0] pend_ch_reg, pend_ch_next;
    logic               out_free;

    assign out_free        = !out_valid_reg || res.ready;
    assign stat.can_emit   = !pend_valid_reg || out_free;
    assign stat.can_finish = out_free;
    assign stat.pend_valid = pend_valid_reg;

    assign res.valid          = out_valid_reg;
    assign res.event_res      = out_ev_reg;
    assign res.target_channel = out_ch_reg;
    assign res.last           = out_last_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg && !res.ready;
        out_ev_next     = out_ev_reg;
        out_ch_next     = out_ch_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_ev_next    = pend_ev_reg;
        pend_ch_next    = pend_ch_reg;
        if (cmd.emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_ev_next    = pend_ev_reg;
                out_ch_next    = pend_ch_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_ev_next    = cmd.ev;
            pend_ch_next    = cmd.ch;
        end
        else if (cmd.finish)
        begin
            out_valid_next  = 1'b1;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
            if (pend_valid_reg)
            begin
                out_ev_next = pend_ev_reg;
                out_ch_next = pend_ch_reg;
            end
            else
            begin
                out_ev_next = EV_NONE;
                out_ch_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_ev_reg   <= out_ev_next;
        out_ch_reg   <= out_ch_next;
        out_last_reg <= out_last_next;
        pend_ev_reg  <= pend_ev_next;
        pend_ch_reg  <= pend_ch_next;
    end
endmodule

[hdl/per_channel_flood_detector_core.sv]
// top level of the per-channel flood detector
// a message passes the entry scan, the entry update and the finish step before its last
// result is loaded into the output register; a disconnect goes straight to the finish step;
// the entry scan reads one memory entry per cycle unless a result cannot yet be staged
// a new message is accepted only after the previous one has finished
// reset: entries invalid, window 2 s, limit 5, no clearing pass needed
module per_channel_flood_detector_core #(
    parameter int CHANNELS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pcfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcfd_pkg::CFG_W-1:0]          cfg_wdata,
    pcfd_msg_if.sink                            msg,
    pcfd_res_if.source                          res
);
    import pcfd_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(CHANNELS + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               eval_v_reg, eval_v_next;
    logic [IDX_W-1:0]   eval_idx_reg, eval_idx_next;
    logic [CH_ID_W-1:0] ch_reg, ch_next;
    logic               det_reg, det_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    entry_t             ent_reg, ent_next;
    logic [CHANNELS-1:0] valid_reg, valid_next;
    logic [CFG_W-1:0]   win_reg, win_next;
    logic [CFG_W-1:0]   lim_reg, lim_next;

    out_cmd_t           cmd;
    out_stat_t          stat;
    logic               mem_we;
    entry_t             mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    entry_t             mem_q;

    logic               expired;
    logic               hit;
    logic               scan_stall;
    logic               scan_last;
    logic               ch_in_range;
    logic [IDX_W-1:0]   ch_idx;
    logic               over;
    logic [CFG_W-1:0]   cnt_inc;
    logic [CFG_W-1:0]   cnt_sat;
    logic               det_fire;
    logic               upd_stall;

    assign expired = valid_reg[eval_idx_reg]
        && (({1'b0, mem_q.start} + {{(TIME_W - CFG_W + 1){1'b0}}, win_reg})
            < {1'b0, now_reg});
    assign hit        = expired && (mem_q.count >= lim_reg);
    assign scan_stall = eval_v_reg && hit && !stat.can_emit;
    assign scan_last  = eval_v_reg && !scan_stall
        && (32'(eval_idx_reg) == 32'(CHANNELS - 1));
    assign ch_in_range = 32'(ch_reg) < 32'(CHANNELS);
    assign ch_idx      = IDX_W'(ch_reg);
    assign over        = ent_reg.count >= lim_reg;
    assign cnt_inc     = ent_reg.count + COUNT_ONE;
    assign cnt_sat     = (ent_reg.count == COUNT_MAX) ? COUNT_MAX : cnt_inc;
    assign det_fire    = cnt_inc >= lim_reg;
    assign upd_stall   = ch_in_range && valid_reg[ch_idx] && !over && det_fire
        && !stat.can_emit;
    assign mem_raddr   = scan_stall ? eval_idx_reg : rd_idx_reg[IDX_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (msg.valid)
                begin
                    state_next = msg.mode ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!upd_stall)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.can_finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        msg.ready     = 1'b0;
        rd_idx_next   = rd_idx_reg;
        eval_v_next   = eval_v_reg;
        eval_idx_next = eval_idx_reg;
        ch_next       = ch_reg;
        det_next      = det_reg;
        now_next      = now_reg;
        ent_next      = ent_reg;
        valid_next    = valid_reg;
        win_next      = win_reg;
        lim_next      = lim_reg;
        cmd           = '0;
        mem_we        = 1'b0;
        mem_wdata     = '{start: now_reg, count: COUNT_ONE};

        if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_SECONDS: win_next = cfg_wdata;
                REG_MESSAGE_LIMIT:  lim_next = cfg_wdata;
                default:            ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                msg.ready = 1'b1;
                if (msg.valid)
                begin
                    ch_next     = msg.channel_id;
                    det_next    = msg.channel_detached;
                    now_next    = msg.now_seconds;
                    rd_idx_next = '0;
                    eval_v_next = 1'b0;
                    if (msg.mode)
                    begin
                        valid_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!scan_stall)
                begin
                    if (eval_v_reg)
                    begin
                        if (expired)
                        begin
                            valid_next[eval_idx_reg] = 1'b0;
                        end
                        if (hit)
                        begin
                            cmd.emit = 1'b1;
                            cmd.ev   = EV_REATTACH;
                            cmd.ch   = CH_ID_W'(eval_idx_reg);
                        end
                        if (32'(eval_idx_reg) == 32'(ch_reg))
                        begin
                            ent_next = mem_q;
                        end
                    end
                    if (32'(rd_idx_reg) < 32'(CHANNELS))
                    begin
                        eval_v_next   = 1'b1;
                        eval_idx_next = rd_idx_reg[IDX_W-1:0];
                        rd_idx_next   = rd_idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        eval_v_next = 1'b0;
                    end
                end
            end
            ST_UPDATE:
            begin
                if (ch_in_range)
                begin
                    if (!valid_reg[ch_idx])
                    begin
                        if (!det_reg)
                        begin
                            valid_next[ch_idx] = 1'b1;
                            mem_we             = 1'b1;
                            mem_wdata          = '{start: now_reg, count: COUNT_ONE};
                        end
                    end
                    else if (over)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = '{start: now_reg, count: cnt_sat};
                    end
                    else if (det_fire)
                    begin
                        if (stat.can_emit)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = '{start: now_reg, count: cnt_inc};
                            cmd.emit  = 1'b1;
                            cmd.ev    = EV_DETACH;
                            cmd.ch    = ch_reg;
                        end
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = '{start: ent_reg.start, count: cnt_inc};
                    end
                end
            end
            ST_FINISH:
            begin
                cmd.finish = stat.can_finish;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_idx_reg <= '0;
            eval_v_reg <= 1'b0;
            valid_reg  <= '0;
            win_reg    <= WINDOW_RESET;
            lim_reg    <= LIMIT_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
            eval_v_reg <= eval_v_next;
            valid_reg  <= valid_next;
            win_reg    <= win_next;
            lim_reg    <= lim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg <= eval_idx_next;
        ch_reg       <= ch_next;
        det_reg      <= det_next;
        now_reg      <= now_next;
        ent_reg      <= ent_next;
    end

    pcfd_entry_mem #(
        .DEPTH (CHANNELS),
        .AW    (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ch_idx),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    pcfd_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .res   (res)
    );

    a_disconnect_clears: assert property (@(posedge clk) disable iff (!rst_n)
        msg.valid && msg.ready && msg.mode |=> valid_reg == '0)
        else $error("disconnect left a tracked entry");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !stat.pend_valid)
        else $error("pending result left over between transactions");

    a_write_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == ST_UPDATE)
        else $error("entry write outside the update step");

    a_eval_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        eval_v_reg |-> 32'(eval_idx_reg) < 32'(CHANNELS))
        else $error("scan index beyond the entry count");
endmodule

[tb/testbench.sv]
// testbench for the per-channel flood detector, checked against a transaction-level predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pcfd_pkg::*;

    localparam int NUM_CHANNELS  = 32;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = NUM_CHANNELS + 8;
    localparam int LONG_HOLD     = 600;

    localparam logic MODE_MESSAGE    = 1'b0;
    localparam logic MODE_DISCONNECT = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [CH_ID_W-1:0] ch;
        logic               detached;
        logic [TIME_W-1:0]  now;
    } flood_msg_t;

    typedef struct packed {
        event_t             ev;
        logic [CH_ID_W-1:0] ch;
        logic               last;
    } flood_event_t;

    class flood_scoreboard;
        logic [CFG_W-1:0]  window_secs;
        logic [CFG_W-1:0]  msg_limit;
        logic              tracked [NUM_CHANNELS];
        logic [TIME_W-1:0] win_start [NUM_CHANNELS];
        logic [CFG_W-1:0]  msg_count [NUM_CHANNELS];
        flood_event_t      pending_events [$];
        int                errors;

        function new();
            window_secs = WINDOW_RESET;
            msg_limit   = LIMIT_RESET;
            errors      = 0;
            foreach (tracked[i])
            begin
                tracked[i]   = 1'b0;
                win_start[i] = '0;
                msg_count[i] = '0;
            end
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == REG_WINDOW_SECONDS)
                window_secs = value;
            else if (idx == REG_MESSAGE_LIMIT)
                msg_limit = value;
        endfunction

        function void push_event(ref flood_event_t produced [$], input event_t ev,
                                 input logic [CH_ID_W-1:0] ch);
            flood_event_t e;
            e.ev   = ev;
            e.ch   = ch;
            e.last = 1'b0;
            produced.push_back(e);
        endfunction

        function void note_message(flood_msg_t m);
            flood_event_t produced [$];
            int           c;
            if (m.mode == MODE_DISCONNECT)
            begin
                foreach (tracked[i])
                    tracked[i] = 1'b0;
            end
            else
            begin
                // expiry sweep, no wrap on the window end
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    if (tracked[i] &&
                        ({1'b0, win_start[i]} + {17'd0, window_secs}) < {1'b0, m.now})
                    begin
                        if (msg_count[i] >= msg_limit)
                            push_event(produced, EV_REATTACH, CH_ID_W'(i));
                        tracked[i] = 1'b0;
                    end
                end
                c = int'(m.ch);
                if (c < NUM_CHANNELS)
                begin
                    if (!tracked[c])
                    begin
                        if (!m.detached)
                        begin
                            tracked[c]   = 1'b1;
                            win_start[c] = m.now;
                            msg_count[c] = COUNT_ONE;
                        end
                    end
                    else if (msg_count[c] >= msg_limit)
                    begin
                        win_start[c] = m.now;
                        if (msg_count[c] != COUNT_MAX)
                            msg_count[c] = msg_count[c] + COUNT_ONE;
                    end
                    else
                    begin
                        msg_count[c] = msg_count[c] + COUNT_ONE;
                        if (msg_count[c] >= msg_limit)
                        begin
                            win_start[c] = m.now;
                            push_event(produced, EV_DETACH, m.ch);
                        end
                    end
                end
            end
            if (produced.size() == 0)
                push_event(produced, EV_NONE, '0);
            produced[produced.size()-1].last = 1'b1;
            foreach (produced[i])
                pending_events.push_back(produced[i]);
        endfunction

        function void check_result(logic [1:0] ev, logic [CH_ID_W-1:0] ch, logic last);
            flood_event_t e;
            if (pending_events.size() == 0)
            begin
                $error("unexpected result: event_res %0d target_channel %0d last %0d",
                       ev, ch, last);
                errors++;
                return;
            end
            e = pending_events.pop_front();
            if (ev !== e.ev)
            begin
                $error("event_res: expected %0d, actual %0d", e.ev, ev);
                errors++;
            end
            if (ch !== e.ch)
            begin
                $error("target_channel: expected %0d, actual %0d", e.ch, ch);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("last: expected %0d, actual %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    pcfd_msg_if msg_ch ();
    pcfd_res_if res_ch ();

    flood_scoreboard      sb;
    logic                 hold_request;
    int                   burst_left;
    logic [TIME_W-1:0]    sim_now;
    logic [CFG_W-1:0]     cur_window;
    logic [CH_ID_W-1:0]   hot [4];

    per_channel_flood_detector_core #(
        .CHANNELS (NUM_CHANNELS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .msg       (msg_ch),
        .res       (res_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic flood_msg_t make_message(logic mode, logic [CH_ID_W-1:0] ch,
                                                logic detached, logic [TIME_W-1:0] now);
        flood_msg_t m;
        m.mode     = mode;
        m.ch       = ch;
        m.detached = detached;
        m.now      = now;
        return m;
    endfunction

    // mostly bursts on a few busy channels with a slowly moving clock
    function automatic flood_msg_t random_message();
        flood_msg_t m;
        int         r;
        r          = $urandom_range(0, 99);
        m.mode     = MODE_MESSAGE;
        m.ch       = hot[$urandom_range(0, 3)];
        m.detached = ($urandom_range(0, 9) == 0);
        m.now      = sim_now;
        if (r < 3)
        begin
            m.mode     = MODE_DISCONNECT;
            m.ch       = CH_ID_W'($urandom());
            m.detached = 1'($urandom_range(0, 1));
            m.now      = TIME_W'($urandom());
        end
        else if (r < 9)
        begin
            m.ch       = CH_ID_W'($urandom());
            m.detached = 1'($urandom_range(0, 1));
            m.now      = TIME_W'($urandom());
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
                sim_now = sim_now + TIME_W'(1);
            else if (r < 28)
                sim_now = sim_now + TIME_W'(cur_window) + TIME_W'($urandom_range(1, 3));
            else if (r < 30)
                sim_now = sim_now + TIME_W'($urandom_range(0, 1000));
            if ($urandom_range(0, 19) == 0)
                hot[$urandom_range(0, 3)] = CH_ID_W'($urandom());
            if ($urandom_range(0, 9) == 0)
                m.ch = CH_ID_W'($urandom());
            m.now = sim_now;
        end
        return m;
    endfunction

    task automatic pause_sender(input int cycles);
        msg_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_item(input flood_msg_t m);
        msg_ch.valid            <= 1'b1;
        msg_ch.mode             <= m.mode;
        msg_ch.channel_id       <= m.ch;
        msg_ch.channel_detached <= m.detached;
        msg_ch.now_seconds      <= m.now;
        @(posedge clk);
        while (!msg_ch.ready)
            @(posedge clk);
        sb.note_message(m);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
            pause_sender($urandom_range(1, 15));
        end
    endtask

    task automatic wait_for_results();
        while (sb.pending_events.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.write_register(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] window, input logic [CFG_W-1:0] limit);
        pause_sender(0);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(REG_WINDOW_SECONDS, window);
        write_register(REG_MESSAGE_LIMIT, limit);
        cur_window = window;
    endtask

    task automatic run_random(input int count, input logic [TIME_W-1:0] base);
        sim_now = base;
        foreach (hot[i])
            hot[i] = CH_ID_W'($urandom());
        repeat (count) send_item(random_message());
    endtask

    task automatic run_directed();
        send_item(make_message(MODE_MESSAGE, 5'd0, 1'b0, 32'd100));
        send_item(make_message(MODE_MESSAGE, 5'd31, 1'b1, 32'd100));
        repeat (5) send_item(make_message(MODE_MESSAGE, 5'd31, 1'b0, 32'd100));
        send_item(make_message(MODE_MESSAGE, 5'd31, 1'b1, 32'd101));
        // clock stepping backwards
        send_item(make_message(MODE_MESSAGE, 5'd5, 1'b0, 32'd90));
        send_item(make_message(MODE_MESSAGE, 5'd0, 1'b0, 32'd105));
        repeat (5) send_item(make_message(MODE_MESSAGE, 5'd1, 1'b0, 32'd200));
        repeat (5) send_item(make_message(MODE_MESSAGE, 5'd2, 1'b0, 32'd201));
        send_item(make_message(MODE_MESSAGE, 5'd4, 1'b0, 32'hFFFF_FFFF));
        send_item(make_message(MODE_DISCONNECT, 5'd17, 1'b1, 32'h5555_AAAA));
        send_item(make_message(MODE_MESSAGE, 5'd4, 1'b0, 32'hFFFF_FFFF));
        send_item(make_message(MODE_MESSAGE, 5'd4, 1'b0, 32'd0));
        send_item(make_message(MODE_MESSAGE, 5'd10, 1'b0, 32'hAAAA_5555));
    endtask

    initial
    begin
        sb                      = new();
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = REG_WINDOW_SECONDS;
        cfg_wdata               = '0;
        msg_ch.valid            = 1'b0;
        msg_ch.mode             = MODE_MESSAGE;
        msg_ch.channel_id       = '0;
        msg_ch.channel_detached = 1'b0;
        msg_ch.now_seconds      = '0;
        hold_request            = 1'b0;
        burst_left              = 1;
        sim_now                 = '0;
        cur_window              = WINDOW_RESET;
        foreach (hot[i])
            hot[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(50, 32'd1000);

        configure(16'd1, 16'd1);
        run_random(60, TIME_W'($urandom()));

        // window end beyond the 32-bit clock range
        configure(16'hFFFF, 16'hFFFF);
        run_random(40, 32'hFFFF_FFF0);

        configure(16'd0, 16'd0);
        run_random(40, 32'd0);

        // long output stall while the input keeps offering
        configure(16'd3, 16'd2);
        hold_request = 1'b1;
        run_random(40, TIME_W'($urandom()));
        pause_sender(0);
        wait_for_results();
        run_random(40, sim_now);

        configure(16'd0, 16'd4);
        run_random(50, TIME_W'($urandom()));

        configure(16'd10, 16'd3);
        run_random(75, TIME_W'($urandom()));

        pause_sender(0);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending_events.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        int   hold_left;
        int   seg_left;
        int   style;
        logic ready_next;
        hold_left    = 0;
        seg_left     = 0;
        style        = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.event_res, res_ch.target_channel, res_ch.last);
            if (seg_left <= 0)
            begin
                style    = $urandom_range(0, 2);
                seg_left = $urandom_range(20, 120);
            end
            seg_left--;
            case (style)
                0:       ready_next = 1'b1;
                1:       ready_next = 1'($urandom_range(0, 1));
                default: ready_next = ($urandom_range(0, 3) != 0);
            endcase
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
                ready_next   = 1'b0;
            end
            res_ch.ready <= ready_next;
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((msg_ch.valid && msg_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end
endmodule
